FILE: rtl/pcbp_pkg.sv
// Package for the prefix code bit packer: word types, command codes, table
// and accumulator sizing. No dependencies.
`timescale 1ns / 1ps

package pcbp_pkg;

   localparam int MAX_CODE_LEN = 32;
   localparam int SYMBOL_COUNT = 256;

   localparam int CODE_W   = 32;
   localparam int LEN_W    = 6;
   localparam int SYM_W    = 8;
   localparam int SYM_IDX_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
   // pending bits never exceed 7 before a merge
   localparam int ACC_W    = MAX_CODE_LEN + 7;
   localparam int CNT_W    = $clog2(ACC_W + 1);
   localparam int Q_DEPTH  = 4;
   localparam int Q_IDX_W  = $clog2(Q_DEPTH);
   localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

   localparam logic [1:0] CMD_LOAD   = 2'd0;
   localparam logic [1:0] CMD_ENCODE = 2'd1;
   localparam logic [1:0] CMD_FLUSH  = 2'd2;

   typedef struct packed {
      logic [1:0]        cmd;
      logic [SYM_W-1:0]  symbol;
      logic [CODE_W-1:0] code_bits;
      logic [LEN_W-1:0]  code_len;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_tail;
      logic [2:0] tail_count;
      logic       last;
   } rsp_type;

   // one queued operation for the packer
   typedef struct packed {
      logic              flush;
      logic [CODE_W-1:0] code;
      logic [LEN_W-1:0]  len;
   } op_type;

   typedef struct packed {
      logic   push;
      op_type op;
   } op_push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

FILE: rtl/prefix_code_bit_packer_top.sv
// Prefix code bit packer: variable-length code table encoder with byte packing.
// Instantiates pcbp_front, pcbp_queue and pcbp_back; uses pcbp_pkg.
//
// Channels: req (valid/stall) carries load, encode and flush words; rsp
// (valid/stall) carries packed bytes MSB first and flush tails.
// Load writes one table slot and gives no output. Encode looks the symbol up
// and appends its code; each completed byte goes out as one rsp word, the
// last of them flagged. Flush sends the 0..7 pending bits as a tail word.
// The table read is registered at acceptance; the word then enters the queue,
// merges into the accumulator and its first byte is loaded into the output
// register. The packer merges a code, then sends its completed bytes one at a
// time before it takes the next queue entry. The front end takes one word per
// cycle until the 4-entry queue fills; then req_stall rises.
// Reset clears the table valid bits, the accumulator and the queue at once;
// no clearing pass. req_stall is high while reset is asserted. While rsp_stall
// is high the output word holds and the packer and queue back up into req_stall.
`timescale 1ns / 1ps

module prefix_code_bit_packer_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pcbp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pcbp_pkg::rsp_type rsp_data
);
   import pcbp_pkg::*;

   op_push_type  q_push;
   q_status_type q_status;
   op_type       head;
   logic         pop;

   pcbp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_status  (q_status),
      .q_push    (q_push)
   );

   pcbp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .q_push   (q_push),
      .pop      (pop),
      .head     (head),
      .q_status (q_status)
   );

   pcbp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_status  (q_status),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   a_tail_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_tail |-> rsp_data.last)
      else $error("tail word without last");

   a_byte_no_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.is_tail |-> rsp_data.tail_count == 3'd0)
      else $error("byte word with nonzero tail count");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push.push |-> !q_status.full)
      else $error("push into full queue");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("pop from empty queue");

endmodule

FILE: rtl/pcbp_front.sv
// Front end: code table (memory plus per-entry valid bits), load handling,
// lookup and classification of encode and flush words. Uses pcbp_pkg.
`timescale 1ns / 1ps

module pcbp_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  pcbp_pkg::req_type     req_data,
   input  pcbp_pkg::q_status_type q_status,
   output pcbp_pkg::op_push_type q_push
);
   import pcbp_pkg::*;

   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_CODE_LEN);

   logic [CODE_W+LEN_W-1:0] mem [SYMBOL_COUNT];
   logic                    vld_ff [SYMBOL_COUNT];

   logic [CODE_W+LEN_W-1:0] rd_ff;
   logic                    rd_vld_ff;
   logic                    s1_valid_ff, s1_valid_in;
   logic [1:0]              s1_cmd_ff;
   logic                    s1_inrange_ff;

   logic                    accept;
   logic                    in_range;
   logic [SYM_IDX_W-1:0]    idx;
   logic [LEN_W-1:0]        sat_len;
   logic [LEN_W-1:0]        rd_len;
   logic                    needs_push;
   logic                    advance;

   assign idx      = req_data.symbol[SYM_IDX_W-1:0];
   assign in_range = {1'b0, req_data.symbol} < (SYM_W+1)'(SYMBOL_COUNT);
   assign sat_len  = (req_data.code_len > MAX_LEN) ? MAX_LEN : req_data.code_len;
   assign accept   = req_valid && !req_stall;
   assign rd_len   = rd_ff[LEN_W-1:0];

   assign needs_push = s1_valid_ff &&
                       ((s1_cmd_ff == CMD_FLUSH) ||
                        ((s1_cmd_ff == CMD_ENCODE) && s1_inrange_ff && rd_vld_ff &&
                         (rd_len != '0)));
   assign advance    = !needs_push || !q_status.full;
   // no word is taken while reset is high
   assign req_stall  = reset || !advance;
   assign s1_valid_in = advance ? accept : s1_valid_ff;

   always_comb begin
      q_push.push     = needs_push && !q_status.full;
      q_push.op.flush = (s1_cmd_ff == CMD_FLUSH);
      q_push.op.code  = rd_ff[CODE_W+LEN_W-1:LEN_W];
      q_push.op.len   = rd_len;
   end

   // table memory; read data registered at accept and held while stalled
   always_ff @(posedge clock) begin
      if (accept && (req_data.cmd == CMD_LOAD) && in_range) begin
         mem[idx] <= {req_data.code_bits, sat_len};
      end
      if (accept) begin
         rd_ff <= mem[idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SYMBOL_COUNT; i++) begin
            vld_ff[i] <= 1'b0;
         end
         rd_vld_ff   <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (accept && (req_data.cmd == CMD_LOAD) && in_range) begin
            vld_ff[idx] <= 1'b1;
         end
         if (accept) begin
            rd_vld_ff <= vld_ff[idx];
         end
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff     <= req_data.cmd;
         s1_inrange_ff <= in_range;
      end
   end

endmodule

FILE: rtl/pcbp_queue.sv
// Small operation queue between the front end and the packer.
// Uses pcbp_pkg.
`timescale 1ns / 1ps

module pcbp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  pcbp_pkg::op_push_type  q_push,
   input  logic                   pop,
   output pcbp_pkg::op_type       head,
   output pcbp_pkg::q_status_type q_status
);
   import pcbp_pkg::*;

   op_type               entry_ff [Q_DEPTH];
   logic [Q_IDX_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [Q_CNT_W-1:0]   count_ff;
   logic                 do_pop;

   assign q_status.full  = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign head           = entry_ff[rd_ptr_ff];
   assign do_pop         = pop && !q_status.empty;

   always_ff @(posedge clock) begin
      if (q_push.push) begin
         entry_ff[wr_ptr_ff] <= q_push.op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (q_push.push) begin
            wr_ptr_ff <= wr_ptr_ff + Q_IDX_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + Q_IDX_W'(1);
         end
         case ({q_push.push, do_pop})
            2'b10:   count_ff <= count_ff + Q_CNT_W'(1);
            2'b01:   count_ff <= count_ff - Q_CNT_W'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

FILE: rtl/pcbp_back.sv
// Back end: bit accumulator, byte extraction and the output word register.
// Uses pcbp_pkg.
`timescale 1ns / 1ps

module pcbp_back (
   input  logic                   clock,
   input  logic                   reset,
   input  pcbp_pkg::op_type       head,
   input  pcbp_pkg::q_status_type q_status,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output pcbp_pkg::rsp_type      rsp_data
);
   import pcbp_pkg::*;

   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             out_ld;
   logic [CNT_W-1:0] cnt_less8;
   logic [ACC_W-1:0] shifted;
   logic [CODE_W:0]  code_mask;
   logic [7:0]       tail_mask;

   assign out_ld    = !rsp_valid_ff || !rsp_stall;
   assign cnt_less8 = cnt_ff - CNT_W'(8);
   assign shifted   = acc_ff >> cnt_less8;
   assign code_mask = ((CODE_W+1)'(1) << head.len) - (CODE_W+1)'(1);
   assign tail_mask = (8'd1 << cnt_ff[2:0]) - 8'd1;

   always_comb begin
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      pop          = 1'b0;
      rsp_in       = rsp_ff;
      rsp_valid_in = out_ld ? 1'b0 : rsp_valid_ff;
      if (cnt_ff >= CNT_W'(8)) begin
         // a full byte is pending: send it before taking more work
         if (out_ld) begin
            rsp_in.out_byte   = shifted[7:0];
            rsp_in.is_tail    = 1'b0;
            rsp_in.tail_count = 3'd0;
            rsp_in.last       = (cnt_less8 < CNT_W'(8));
            rsp_valid_in      = 1'b1;
            cnt_in            = cnt_less8;
         end
      end else if (!q_status.empty) begin
         if (head.flush) begin
            if (out_ld) begin
               rsp_in.out_byte   = {1'b0, acc_ff[6:0]} & tail_mask;
               rsp_in.is_tail    = 1'b1;
               rsp_in.tail_count = cnt_ff[2:0];
               rsp_in.last       = 1'b1;
               rsp_valid_in      = 1'b1;
               acc_in            = '0;
               cnt_in            = '0;
               pop               = 1'b1;
            end
         end else begin
            // bits above cnt are stale and stay above it after the shift
            acc_in = (acc_ff << head.len) | ACC_W'(head.code & code_mask[CODE_W-1:0]);
            cnt_in = cnt_ff + CNT_W'(head.len);
            pop    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: tb/sv/prefix_code_bit_packer_top_test.sv
// Self-checking testbench for prefix_code_bit_packer_top: table loads, encodes,
// flushes and unused commands, checked against an in-bench packer model.
// Depends on pcbp_pkg and the prefix_code_bit_packer_top RTL.
`timescale 1ns / 1ps

module prefix_code_bit_packer_top_test;
   import pcbp_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int HOLD_CYCLES = 300;
   localparam int STUCK_LIMIT = 4000;
   localparam int POOL_SIZE   = 12;

   // Tracks the code table and pending bits; queues the words the block owes.
   class packed_byte_tracker;
      logic [CODE_W-1:0] code_mem [SYMBOL_COUNT];
      logic [LEN_W-1:0]  len_mem [SYMBOL_COUNT];
      logic [6:0]        pend_bits;
      logic [2:0]        pend_count;
      rsp_type           owed_q [$];
      int                mismatches;

      function new();
         for (int i = 0; i < SYMBOL_COUNT; i++) begin
            code_mem[i] = '0;
            len_mem[i]  = '0;
         end
         pend_bits  = '0;
         pend_count = '0;
         mismatches = 0;
      endfunction

      function void note_word(req_type w);
         logic [63:0]      merged;
         logic [LEN_W-1:0] clen;
         int               total;
         int               nbytes;
         int               rem;
         rsp_type          r;
         r = '0;
         case (w.cmd)
            CMD_LOAD: begin
               if (int'(w.symbol) < SYMBOL_COUNT) begin
                  code_mem[w.symbol] = w.code_bits;
                  len_mem[w.symbol]  = (w.code_len > MAX_CODE_LEN) ?
                                       LEN_W'(MAX_CODE_LEN) : w.code_len;
               end
            end
            CMD_ENCODE: begin
               if (int'(w.symbol) < SYMBOL_COUNT && len_mem[w.symbol] != 0) begin
                  clen   = len_mem[w.symbol];
                  merged = ({57'd0, pend_bits} << clen) |
                           ({32'd0, code_mem[w.symbol]} & ((64'd1 << clen) - 64'd1));
                  total  = int'(pend_count) + int'(clen);
                  nbytes = total / 8;
                  for (int k = 0; k < nbytes; k++) begin
                     rem        = total - 8 * (k + 1);
                     r.out_byte = 8'(merged >> rem);
                     r.last     = (k == nbytes - 1);
                     owed_q.push_back(r);
                  end
                  rem        = total % 8;
                  pend_bits  = 7'(merged & ((64'd1 << rem) - 64'd1));
                  pend_count = 3'(rem);
               end
            end
            CMD_FLUSH: begin
               r.out_byte   = {1'b0, pend_bits};
               r.is_tail    = 1'b1;
               r.tail_count = pend_count;
               r.last       = 1'b1;
               owed_q.push_back(r);
               pend_bits  = '0;
               pend_count = '0;
            end
            default: ;
         endcase
      endfunction

      function void report(string what, rsp_type want, rsp_type got);
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch (%s): want %h/%b/%0d/%b got %h/%b/%0d/%b",
                     what, want.out_byte, want.is_tail, want.tail_count, want.last,
                     got.out_byte, got.is_tail, got.tail_count, got.last);
      endfunction

      function void check_word(rsp_type got);
         rsp_type want;
         if (owed_q.size() == 0) begin
            report("unexpected word", '0, got);
            return;
         end
         want = owed_q.pop_front();
         if (got.out_byte !== want.out_byte || got.is_tail !== want.is_tail ||
             got.tail_count !== want.tail_count || got.last !== want.last)
            report("field", want, got);
      endfunction

      function int pending();
         return owed_q.size();
      endfunction
   endclass

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   packed_byte_tracker tracker;
   int idle_pct    = 0;
   int stall_pct   = 0;
   int hold_ticket = 0;
   int hold_seen   = 0;
   int hold_left   = 0;
   int stuck       = 0;
   logic [7:0] sym_pool [POOL_SIZE];

   prefix_code_bit_packer_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver: random stalls, plus a long hold-off when the sender asks for one
   always @(posedge clock) begin
      if (hold_ticket != hold_seen) begin
         hold_seen = hold_ticket;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_word(rsp_data);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         stuck <= 0;
      else
         stuck <= stuck + 1;
      if (stuck == STUCK_LIMIT) begin
         $display("[prefix_code_bit_packer_top] ERROR");
         $finish;
      end
   end

   function automatic req_type make_word(logic [1:0] cmd, logic [7:0] sym,
                                         logic [31:0] bits, logic [5:0] len);
      req_type w;
      w.cmd       = cmd;
      w.symbol    = sym;
      w.code_bits = bits;
      w.code_len  = len;
      return w;
   endfunction

   task automatic send_word(req_type w);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.note_word(w);
   endtask

   // sender pause until the block has returned every owed word
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   initial begin
      int         pick;
      int         lsel;
      logic [7:0] sym;
      logic [5:0] len;
      tracker = new();
      for (int i = 0; i < POOL_SIZE; i++)
         sym_pool[i] = 8'($urandom_range(255));
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty flush, absent symbol, extremes of code and length
      send_word(make_word(CMD_FLUSH, 8'h00, 32'h0, 6'd0));
      send_word(make_word(CMD_ENCODE, 8'h00, 32'h0, 6'd0));
      send_word(make_word(CMD_LOAD, 8'hFF, 32'hFFFF_FFFF, 6'd32));
      send_word(make_word(CMD_ENCODE, 8'hFF, 32'h0, 6'd0));
      send_word(make_word(CMD_LOAD, 8'h00, 32'h0, 6'd63));
      send_word(make_word(CMD_ENCODE, 8'h00, 32'hFFFF_FFFF, 6'd63));
      // upper code bits beyond the length must be masked off
      send_word(make_word(CMD_LOAD, 8'h5A, 32'hFFFF_FFFA, 6'd3));
      send_word(make_word(CMD_ENCODE, 8'h5A, 32'h0, 6'd0));
      send_word(make_word(CMD_FLUSH, 8'hFF, 32'hFFFF_FFFF, 6'd63));
      send_word(make_word(CMD_LOAD, 8'hA5, 32'h1, 6'd1));
      repeat (7) send_word(make_word(CMD_ENCODE, 8'hA5, 32'h0, 6'd0));
      send_word(make_word(CMD_FLUSH, 8'h00, 32'h0, 6'd0));
      send_word(make_word(CMD_LOAD, 8'hA5, 32'hFFFF_FFFF, 6'd0));
      send_word(make_word(CMD_ENCODE, 8'hA5, 32'h0, 6'd0));
      send_word(make_word(CMD_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'd63));
      send_word(make_word(CMD_LOAD, 8'h3C, 32'h1234_5678, 6'd33));
      send_word(make_word(CMD_ENCODE, 8'h5A, 32'h0, 6'd0));
      send_word(make_word(CMD_ENCODE, 8'h3C, 32'h0, 6'd0));
      send_word(make_word(CMD_FLUSH, 8'h00, 32'h0, 6'd0));
      drain();

      // back-pressure: receiver holds off while 32-bit codes pile up
      hold_ticket = hold_ticket + 1;
      repeat (16) send_word(make_word(CMD_ENCODE, 8'hFF, 32'h0, 6'd0));
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 53; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 53; end
            default: begin idle_pct = 16; stall_pct = 16; end
         endcase
         repeat (45) begin
            pick = $urandom_range(99);
            sym  = ($urandom_range(99) < 85) ? sym_pool[$urandom_range(POOL_SIZE - 1)] :
                                               8'($urandom_range(255));
            if (pick < 22) begin
               lsel = $urandom_range(99);
               if (lsel < 70)      len = 6'($urandom_range(10, 1));
               else if (lsel < 90) len = 6'($urandom_range(32, 11));
               else if (lsel < 97) len = 6'($urandom_range(63, 33));
               else                len = 6'd0;
               send_word(make_word(CMD_LOAD, sym, $urandom(), len));
            end else if (pick < 82) begin
               send_word(make_word(CMD_ENCODE, sym, $urandom(), 6'($urandom_range(63))));
            end else if (pick < 94) begin
               send_word(make_word(CMD_FLUSH, sym, $urandom(), 6'($urandom_range(63))));
            end else begin
               send_word(make_word(CMD_UNUSED, sym, $urandom(), 6'($urandom_range(63))));
            end
         end
         drain();
      end

      idle_pct  = 0;
      stall_pct = 0;
      drain();
      repeat (20) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending() == 0)
         $display("[prefix_code_bit_packer_top] OK");
      else
         $display("[prefix_code_bit_packer_top] ERROR");
      $finish;
   end

endmodule
